### rtl/perlin_noise_2d_core_assert.svh
// Assertion macros for the noise core; clock i_clk, reset i_rst_n.
`ifndef PERLIN_NOISE_2D_CORE_ASSERT_SVH
`define PERLIN_NOISE_2D_CORE_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define PN2D_CHK_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("pipeline check failed");

// Check that cons holds in the cycle after ante.
`define PN2D_CHK_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("pipeline check failed");

`endif

### rtl/pn2d_pkg.sv
`timescale 1ns / 1ps

package pn2d_pkg;

    // Fixed-point format
    localparam int FRAC_BITS = 12;
    localparam int FX_ONE    = 1 << FRAC_BITS;
    localparam int FX_HALF   = 1 << (FRAC_BITS - 1);
    localparam int FX_LIM    = 2 * FX_ONE;

    // Field widths
    localparam int COORD_W   = 20;
    localparam int BYTE_W    = 8;
    localparam int OUT_W     = 15;
    localparam int TBL_DEPTH = 256;

    // Fade polynomial 6t^5 - 15t^4 + 10t^3
    localparam int FADE_C5 = 6;
    localparam int FADE_C4 = 15;
    localparam int FADE_C3 = 10;

    // Gradient selections that use x as the second term
    localparam logic [3:0] GRAD_X_ALT_A = 4'd12;
    localparam logic [3:0] GRAD_X_ALT_B = 4'd14;

    localparam int DIFF_W = FRAC_BITS + 4;
    localparam int RES_W  = (DIFF_W > OUT_W) ? DIFF_W : OUT_W;

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_EVAL = 1'b1
    } t_op;

    typedef logic [BYTE_W-1:0]              t_byte;
    typedef logic [COORD_W-1:0]             t_coord;
    typedef logic [FRAC_BITS-1:0]           t_frac;
    typedef logic [2*FRAC_BITS-1:0]         t_sq;
    typedef logic [FRAC_BITS:0]             t_fade;
    typedef logic [FRAC_BITS+5:0]           t_poly;
    typedef logic [2*FRAC_BITS:0]           t_cube;
    typedef logic [2*FRAC_BITS+5:0]         t_fprod;
    typedef logic signed [FRAC_BITS+2:0]    t_dot;
    typedef logic signed [DIFF_W-1:0]       t_diff;
    typedef logic signed [2*FRAC_BITS+5:0]  t_bprod;
    typedef logic signed [RES_W-1:0]        t_res;
    typedef logic signed [OUT_W-1:0]        t_noise;

endpackage

### rtl/pn2d_ram.sv
`timescale 1ns / 1ps

module pn2d_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    // Write one word
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read two words, hold while not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata_a <= r_mem[i_raddr_a];
            r_rdata_b <= r_mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

### rtl/perlin_noise_2d_core.sv
// Pipeline: stage 1 loads an evaluate word at the accepting edge; stages 2 to 7 and
// the output register follow, and the output register offers the result.
// Throughput: one word per cycle while the output is not stalled; permutation reads
// use three table copies, one for the first hash level and a pair for the second, each
// written at the stage reading it. Reset: clears all stage valid bits and the output
// valid; the table keeps its contents and is undefined until loaded.
`timescale 1ns / 1ps

`include "perlin_noise_2d_core_assert.svh"

module perlin_noise_2d_core (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic                    i_opcode,
    input  pn2d_pkg::t_byte         i_table_index,
    input  pn2d_pkg::t_byte         i_table_value,
    input  pn2d_pkg::t_coord        i_x_coord,
    input  pn2d_pkg::t_coord        i_y_coord,
    output logic                    o_valid,
    input  logic                    i_ready,
    output pn2d_pkg::t_noise        o_noise_value
);

    // Gradient dot product for the low four hash bits
    function automatic pn2d_pkg::t_dot f_grad(
        input logic [3:0]      sel,
        input pn2d_pkg::t_dot  dx,
        input pn2d_pkg::t_dot  dy
    );
        pn2d_pkg::t_dot p;
        pn2d_pkg::t_dot q;
        p = sel[3] ? dy : dx;
        if (sel[3:2] == 2'b00) begin
            q = dy;
        end else if (sel == pn2d_pkg::GRAD_X_ALT_A || sel == pn2d_pkg::GRAD_X_ALT_B) begin
            q = dx;
        end else begin
            q = '0;
        end
        return (sel[0] ? -p : p) + (sel[1] ? -q : q);
    endfunction

    // Stage control
    logic [7:1] r_vld;
    logic       r_o_vld;
    logic [8:1] w_en;

    // Stage 1
    pn2d_pkg::t_op    r_s1_op;
    pn2d_pkg::t_byte  r_s1_idx;
    pn2d_pkg::t_byte  r_s1_val;
    pn2d_pkg::t_byte  r_s1_yi;
    pn2d_pkg::t_frac  r_s1_frac [2];
    pn2d_pkg::t_sq    r_s1_sq   [2];
    // Stage 2
    pn2d_pkg::t_frac  r_s2_frac [2];
    pn2d_pkg::t_poly  r_s2_poly [2];
    pn2d_pkg::t_cube  r_s2_cube [2];
    // Stage 3
    pn2d_pkg::t_fprod r_s3_fprod [2];
    pn2d_pkg::t_dot   r_s3_daa;
    pn2d_pkg::t_dot   r_s3_dba;
    pn2d_pkg::t_dot   r_s3_dab;
    pn2d_pkg::t_dot   r_s3_dbb;
    // Stage 4
    pn2d_pkg::t_fade  r_s4_fade [2];
    pn2d_pkg::t_dot   r_s4_alo;
    pn2d_pkg::t_dot   r_s4_ahi;
    pn2d_pkg::t_diff  r_s4_dlo;
    pn2d_pkg::t_diff  r_s4_dhi;
    // Stage 5
    pn2d_pkg::t_bprod r_s5_plo;
    pn2d_pkg::t_bprod r_s5_phi;
    pn2d_pkg::t_dot   r_s5_alo;
    pn2d_pkg::t_dot   r_s5_ahi;
    pn2d_pkg::t_fade  r_s5_fv;
    // Stage 6
    pn2d_pkg::t_dot   r_s6_lo;
    pn2d_pkg::t_diff  r_s6_d;
    pn2d_pkg::t_fade  r_s6_fv;
    // Stage 7
    pn2d_pkg::t_dot   r_s7_lo;
    pn2d_pkg::t_bprod r_s7_p;
    // Output
    pn2d_pkg::t_noise r_out_noise;

    // Combinational
    pn2d_pkg::t_byte  w_xi;
    pn2d_pkg::t_byte  w_xi1;
    pn2d_pkg::t_byte  w_yi;
    pn2d_pkg::t_frac  w_frac [2];
    pn2d_pkg::t_byte  w_pa;
    pn2d_pkg::t_byte  w_pb;
    pn2d_pkg::t_byte  w_ha;
    pn2d_pkg::t_byte  w_hb;
    pn2d_pkg::t_byte  w_caa;
    pn2d_pkg::t_byte  w_cab;
    pn2d_pkg::t_byte  w_cba;
    pn2d_pkg::t_byte  w_cbb;
    pn2d_pkg::t_fade  w_t2   [2];
    pn2d_pkg::t_poly  w_poly [2];
    pn2d_pkg::t_fade  w_t3   [2];
    pn2d_pkg::t_fprod w_fr   [2];
    pn2d_pkg::t_fade  w_fade [2];
    pn2d_pkg::t_dot   w_dx0;
    pn2d_pkg::t_dot   w_dx1;
    pn2d_pkg::t_dot   w_dy0;
    pn2d_pkg::t_dot   w_dy1;
    pn2d_pkg::t_bprod w_fu_s;
    pn2d_pkg::t_bprod w_fv_s;
    pn2d_pkg::t_bprod w_rlo;
    pn2d_pkg::t_bprod w_rhi;
    pn2d_pkg::t_diff  w_lo;
    pn2d_pkg::t_diff  w_hi;
    pn2d_pkg::t_bprod w_rres;
    pn2d_pkg::t_diff  w_res;
    pn2d_pkg::t_diff  w_clamp;
    pn2d_pkg::t_res   w_res_wide;
    logic             w_we_a;
    logic             w_we_b;

    // Advance a stage when it is empty or the next one moves
    always_comb begin
        w_en[8] = !r_o_vld || i_ready;
        for (int k = 7; k >= 1; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
    end

    assign o_ready = w_en[1];
    assign o_valid = r_o_vld;
    assign o_noise_value = r_out_noise;

    // Split coordinates into cell and fraction
    assign w_xi  = pn2d_pkg::t_byte'(i_x_coord >> pn2d_pkg::FRAC_BITS);
    assign w_yi  = pn2d_pkg::t_byte'(i_y_coord >> pn2d_pkg::FRAC_BITS);
    assign w_xi1 = w_xi + pn2d_pkg::t_byte'(1);
    assign w_frac[0] = i_x_coord[pn2d_pkg::FRAC_BITS-1:0];
    assign w_frac[1] = i_y_coord[pn2d_pkg::FRAC_BITS-1:0];

    // First hash level: table copy read at acceptance
    assign w_we_a = i_valid && w_en[1] && (i_opcode == pn2d_pkg::OP_LOAD);

    pn2d_ram #(
        .WIDTH (pn2d_pkg::BYTE_W),
        .DEPTH (pn2d_pkg::TBL_DEPTH)
    ) u_tbl_a (
        .i_clk     (i_clk),
        .i_we      (w_we_a),
        .i_waddr   (i_table_index),
        .i_wdata   (i_table_value),
        .i_re      (w_en[1]),
        .i_raddr_a (w_xi),
        .i_raddr_b (w_xi1),
        .o_rdata_a (w_pa),
        .o_rdata_b (w_pb)
    );

    // Second hash level: two table copies read from stage 1
    assign w_ha   = w_pa + r_s1_yi;
    assign w_hb   = w_pb + r_s1_yi;
    assign w_we_b = r_vld[1] && w_en[2] && (r_s1_op == pn2d_pkg::OP_LOAD);

    pn2d_ram #(
        .WIDTH (pn2d_pkg::BYTE_W),
        .DEPTH (pn2d_pkg::TBL_DEPTH)
    ) u_tbl_b0 (
        .i_clk     (i_clk),
        .i_we      (w_we_b),
        .i_waddr   (r_s1_idx),
        .i_wdata   (r_s1_val),
        .i_re      (w_en[2]),
        .i_raddr_a (w_ha),
        .i_raddr_b (w_ha + pn2d_pkg::t_byte'(1)),
        .o_rdata_a (w_caa),
        .o_rdata_b (w_cab)
    );

    pn2d_ram #(
        .WIDTH (pn2d_pkg::BYTE_W),
        .DEPTH (pn2d_pkg::TBL_DEPTH)
    ) u_tbl_b1 (
        .i_clk     (i_clk),
        .i_we      (w_we_b),
        .i_waddr   (r_s1_idx),
        .i_wdata   (r_s1_val),
        .i_re      (w_en[2]),
        .i_raddr_a (w_hb),
        .i_raddr_b (w_hb + pn2d_pkg::t_byte'(1)),
        .o_rdata_a (w_cba),
        .o_rdata_b (w_cbb)
    );

    // Fade lanes: round the square, form the polynomial, round the cube, scale
    always_comb begin
        for (int a = 0; a < 2; a++) begin
            w_t2[a] = pn2d_pkg::t_fade'((r_s1_sq[a] + pn2d_pkg::t_sq'(pn2d_pkg::FX_HALF))
                                        >> pn2d_pkg::FRAC_BITS);
            w_poly[a] = pn2d_pkg::t_poly'(w_t2[a]) * pn2d_pkg::t_poly'(pn2d_pkg::FADE_C5)
                      + pn2d_pkg::t_poly'(pn2d_pkg::FX_ONE * pn2d_pkg::FADE_C3)
                      - pn2d_pkg::t_poly'(r_s1_frac[a]) * pn2d_pkg::t_poly'(pn2d_pkg::FADE_C4);
            w_t3[a] = pn2d_pkg::t_fade'((r_s2_cube[a] + pn2d_pkg::t_cube'(pn2d_pkg::FX_HALF))
                                        >> pn2d_pkg::FRAC_BITS);
            w_fr[a] = (r_s3_fprod[a] + pn2d_pkg::t_fprod'(pn2d_pkg::FX_HALF))
                      >> pn2d_pkg::FRAC_BITS;
            w_fade[a] = (w_fr[a] > pn2d_pkg::t_fprod'(pn2d_pkg::FX_ONE))
                      ? pn2d_pkg::t_fade'(pn2d_pkg::FX_ONE) : pn2d_pkg::t_fade'(w_fr[a]);
        end
    end

    // Corner offsets
    assign w_dx0 = pn2d_pkg::t_dot'(r_s2_frac[0]);
    assign w_dy0 = pn2d_pkg::t_dot'(r_s2_frac[1]);
    assign w_dx1 = w_dx0 - pn2d_pkg::t_dot'(pn2d_pkg::FX_ONE);
    assign w_dy1 = w_dy0 - pn2d_pkg::t_dot'(pn2d_pkg::FX_ONE);

    // Blend arithmetic
    assign w_fu_s = pn2d_pkg::t_bprod'($signed({1'b0, r_s4_fade[0]}));
    assign w_fv_s = pn2d_pkg::t_bprod'($signed({1'b0, r_s6_fv}));
    assign w_rlo  = (r_s5_plo + pn2d_pkg::t_bprod'(pn2d_pkg::FX_HALF)) >>> pn2d_pkg::FRAC_BITS;
    assign w_rhi  = (r_s5_phi + pn2d_pkg::t_bprod'(pn2d_pkg::FX_HALF)) >>> pn2d_pkg::FRAC_BITS;
    assign w_lo   = pn2d_pkg::t_diff'(r_s5_alo) + pn2d_pkg::t_diff'(w_rlo);
    assign w_hi   = pn2d_pkg::t_diff'(r_s5_ahi) + pn2d_pkg::t_diff'(w_rhi);
    assign w_rres = (r_s7_p + pn2d_pkg::t_bprod'(pn2d_pkg::FX_HALF)) >>> pn2d_pkg::FRAC_BITS;
    assign w_res  = pn2d_pkg::t_diff'(r_s7_lo) + pn2d_pkg::t_diff'(w_rres);

    // Clamp to plus or minus two and fit the output field
    always_comb begin
        if (w_res > pn2d_pkg::t_diff'(pn2d_pkg::FX_LIM)) begin
            w_clamp = pn2d_pkg::t_diff'(pn2d_pkg::FX_LIM);
        end else if (w_res < -pn2d_pkg::t_diff'(pn2d_pkg::FX_LIM)) begin
            w_clamp = -pn2d_pkg::t_diff'(pn2d_pkg::FX_LIM);
        end else begin
            w_clamp = w_res;
        end
        w_res_wide = pn2d_pkg::t_res'(w_clamp);
    end

    // Valid bits; loads drop out after stage 1
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= '0;
            r_o_vld <= 1'b0;
        end else begin
            if (w_en[1]) begin
                r_vld[1] <= i_valid;
            end
            if (w_en[2]) begin
                r_vld[2] <= r_vld[1] && (r_s1_op == pn2d_pkg::OP_EVAL);
            end
            for (int k = 3; k <= 7; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
            if (w_en[8]) begin
                r_o_vld <= r_vld[7];
            end
        end
    end

    // Stage 1: capture word, square fractions
    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r_s1_op  <= pn2d_pkg::t_op'(i_opcode);
            r_s1_idx <= i_table_index;
            r_s1_val <= i_table_value;
            r_s1_yi  <= w_yi;
            for (int a = 0; a < 2; a++) begin
                r_s1_frac[a] <= w_frac[a];
                r_s1_sq[a]   <= pn2d_pkg::t_sq'(w_frac[a]) * pn2d_pkg::t_sq'(w_frac[a]);
            end
        end
    end

    // Stage 2: polynomial, cube product
    always_ff @(posedge i_clk) begin
        if (w_en[2]) begin
            for (int a = 0; a < 2; a++) begin
                r_s2_frac[a] <= r_s1_frac[a];
                r_s2_poly[a] <= w_poly[a][pn2d_pkg::FRAC_BITS+5] ? '0 : w_poly[a];
                r_s2_cube[a] <= pn2d_pkg::t_cube'(w_t2[a]) * pn2d_pkg::t_cube'(r_s1_frac[a]);
            end
        end
    end

    // Stage 3: fade product, corner gradients
    always_ff @(posedge i_clk) begin
        if (w_en[3]) begin
            for (int a = 0; a < 2; a++) begin
                r_s3_fprod[a] <= pn2d_pkg::t_fprod'(w_t3[a]) * pn2d_pkg::t_fprod'(r_s2_poly[a]);
            end
            r_s3_daa <= f_grad(w_caa[3:0], w_dx0, w_dy0);
            r_s3_dba <= f_grad(w_cba[3:0], w_dx1, w_dy0);
            r_s3_dab <= f_grad(w_cab[3:0], w_dx0, w_dy1);
            r_s3_dbb <= f_grad(w_cbb[3:0], w_dx1, w_dy1);
        end
    end

    // Stage 4: fade weights, corner differences
    always_ff @(posedge i_clk) begin
        if (w_en[4]) begin
            r_s4_fade <= w_fade;
            r_s4_alo  <= r_s3_daa;
            r_s4_ahi  <= r_s3_dab;
            r_s4_dlo  <= pn2d_pkg::t_diff'(r_s3_dba) - pn2d_pkg::t_diff'(r_s3_daa);
            r_s4_dhi  <= pn2d_pkg::t_diff'(r_s3_dbb) - pn2d_pkg::t_diff'(r_s3_dab);
        end
    end

    // Stage 5: weight the x differences
    always_ff @(posedge i_clk) begin
        if (w_en[5]) begin
            r_s5_plo <= w_fu_s * pn2d_pkg::t_bprod'(r_s4_dlo);
            r_s5_phi <= w_fu_s * pn2d_pkg::t_bprod'(r_s4_dhi);
            r_s5_alo <= r_s4_alo;
            r_s5_ahi <= r_s4_ahi;
            r_s5_fv  <= r_s4_fade[1];
        end
    end

    // Stage 6: finish x blends, form the y difference
    always_ff @(posedge i_clk) begin
        if (w_en[6]) begin
            r_s6_lo <= pn2d_pkg::t_dot'(w_lo);
            r_s6_d  <= w_hi - w_lo;
            r_s6_fv <= r_s5_fv;
        end
    end

    // Stage 7: weight the y difference
    always_ff @(posedge i_clk) begin
        if (w_en[7]) begin
            r_s7_lo <= r_s6_lo;
            r_s7_p  <= w_fv_s * pn2d_pkg::t_bprod'(r_s6_d);
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (w_en[8]) begin
            r_out_noise <= w_res_wide[pn2d_pkg::OUT_W-1:0];
        end
    end

    // Checks
    `PN2D_CHK_NEXT(a_load_dropped, r_vld[1] && (r_s1_op == pn2d_pkg::OP_LOAD) && w_en[2], !r_vld[2])
    `PN2D_CHK_NEXT(a_stage7_held, r_vld[7] && !w_en[8], r_vld[7] && $stable(r_s7_p))
    `PN2D_CHK_NOW(a_out_from_s7, $rose(r_o_vld), $past(r_vld[7]))

endmodule

### test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import pn2d_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int RAND_WORDS  = 1024;
    localparam int DRAIN_WAIT  = 24;
    localparam int HOLD_AT     = 500;
    localparam int HOLD_LEN    = 400;

    typedef struct {
        t_op    op;
        t_byte  idx;
        t_byte  val;
        t_coord x;
        t_coord y;
    } pn_word_t;

    logic   i_clk   = 1'b0;
    logic   i_rst_n = 1'b0;

    // Sender side
    logic   tx_valid = 1'b0;
    t_op    tx_op    = OP_LOAD;
    t_byte  tx_idx   = '0;
    t_byte  tx_val   = '0;
    t_coord tx_x     = '0;
    t_coord tx_y     = '0;
    logic   o_ready;

    // Receiver side
    logic   rx_ready = 1'b0;
    logic   o_valid;
    t_noise o_noise_value;

    pn_word_t word_q[$];
    t_noise   noise_expected[$];
    t_byte    perm_shadow[256];
    t_byte    perm_plan[256];

    int tx_gap    = 0;
    int rx_gap    = 0;
    int sent_cnt  = 0;
    int rcv_cnt   = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;
    int err_cnt   = 0;
    int cyc_cnt   = 0;

    perlin_noise_2d_core u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (tx_valid),
        .o_ready       (o_ready),
        .i_opcode      (tx_op),
        .i_table_index (tx_idx),
        .i_table_value (tx_val),
        .i_x_coord     (tx_x),
        .i_y_coord     (tx_y),
        .o_valid       (o_valid),
        .i_ready       (rx_ready),
        .o_noise_value (o_noise_value)
    );

    // Free-running clock
    always #4 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Noise predictor: fixed-point improved gradient noise
    // ------------------------------------------------------------------

    // Scale a product back to the fraction width, round half up
    function automatic longint fx_scale(longint p);
        return (p + FX_HALF) >>> FRAC_BITS;
    endfunction

    function automatic longint fade_curve(longint t);
        longint t2, poly, t3, r;
        t2   = fx_scale(t * t);
        poly = FADE_C5 * t2 + FADE_C3 * FX_ONE - FADE_C4 * t;
        if (poly < 0)
            poly = 0;
        t3 = fx_scale(t2 * t);
        r  = fx_scale(t3 * poly);
        if (r > FX_ONE)
            r = FX_ONE;
        if (r < 0)
            r = 0;
        return r;
    endfunction

    function automatic longint mix_lin(longint w, longint a, longint b);
        return a + fx_scale(w * (b - a));
    endfunction

    // Dot product of the offset with the gradient picked by the low hash bits
    function automatic longint grad_dot(t_byte h, longint dx, longint dy);
        logic [3:0] sel;
        longint     p, q;
        sel = h[3:0];
        p   = (sel < 4'd8) ? dx : dy;
        if (sel < 4'd4)
            q = dy;
        else if (sel == GRAD_X_ALT_A || sel == GRAD_X_ALT_B)
            q = dx;
        else
            q = 0;
        return (sel[0] ? -p : p) + (sel[1] ? -q : q);
    endfunction

    function automatic t_noise noise_at(t_coord x, t_coord y);
        t_byte  xi, yi, ha, hb;
        t_byte  c_aa, c_ab, c_ba, c_bb;
        longint xf, yf, fu, fv, lo, hi, res;
        xi = t_byte'(x >> FRAC_BITS);
        yi = t_byte'(y >> FRAC_BITS);
        xf = longint'(x[FRAC_BITS-1:0]);
        yf = longint'(y[FRAC_BITS-1:0]);
        fu = fade_curve(xf);
        fv = fade_curve(yf);
        ha   = perm_shadow[xi] + yi;
        hb   = perm_shadow[t_byte'(xi + 8'd1)] + yi;
        c_aa = perm_shadow[ha];
        c_ab = perm_shadow[t_byte'(ha + 8'd1)];
        c_ba = perm_shadow[hb];
        c_bb = perm_shadow[t_byte'(hb + 8'd1)];
        lo  = mix_lin(fu, grad_dot(c_aa, xf, yf), grad_dot(c_ba, xf - FX_ONE, yf));
        hi  = mix_lin(fu, grad_dot(c_ab, xf, yf - FX_ONE),
                      grad_dot(c_bb, xf - FX_ONE, yf - FX_ONE));
        res = mix_lin(fv, lo, hi);
        if (res > FX_LIM)
            res = FX_LIM;
        if (res < -FX_LIM)
            res = -FX_LIM;
        return t_noise'(res);
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Gap length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 50);
    endfunction

    // Random coordinate, biased towards the fraction extremes and one half
    function automatic t_coord pick_coord();
        t_coord c;
        c = t_coord'($urandom_range(0, 20'hFFFFF));
        case ($urandom_range(0, 9))
            0: c[FRAC_BITS-1:0] = '0;
            1: c[FRAC_BITS-1:0] = '1;
            2: c[FRAC_BITS-1:0] = t_frac'(FX_HALF);
            default: ;
        endcase
        return c;
    endfunction

    // Queue a load word; the coordinate fields carry junk
    function automatic void queue_load(t_byte idx, t_byte val);
        pn_word_t w;
        w.op  = OP_LOAD;
        w.idx = idx;
        w.val = val;
        w.x   = t_coord'($urandom_range(0, 20'hFFFFF));
        w.y   = t_coord'($urandom_range(0, 20'hFFFFF));
        perm_plan[idx] = val;
        word_q.push_back(w);
    endfunction

    // Queue an evaluate word; the table fields carry junk
    function automatic void queue_eval(t_coord x, t_coord y);
        pn_word_t w;
        w.op  = OP_EVAL;
        w.idx = t_byte'($urandom_range(0, 255));
        w.val = t_byte'($urandom_range(0, 255));
        w.x   = x;
        w.y   = y;
        word_q.push_back(w);
    endfunction

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------
    initial begin : stim_proc
        t_byte  order[256];
        t_byte  tmp, idx;
        t_coord cx, cy;
        int     j, n_rand, n_hit;

        // Fill the whole table first with a shuffled permutation
        for (int i = 0; i < 256; i++)
            order[i] = t_byte'(i);
        for (int i = 255; i > 0; i--) begin
            j        = $urandom_range(0, i);
            tmp      = order[i];
            order[i] = order[j];
            order[j] = tmp;
        end
        for (int i = 0; i < 256; i++)
            queue_load(t_byte'(i), order[i]);

        // Corners of the coordinate range and fraction extremes
        queue_eval(20'h00000, 20'h00000);
        queue_eval(20'hFFFFF, 20'hFFFFF);
        queue_eval(20'h00000, 20'hFFFFF);
        queue_eval(20'hFFFFF, 20'h00000);
        queue_eval(20'hFF000, 20'hFF000);
        queue_eval(20'h00FFF, 20'h00FFF);
        queue_eval(20'h00001, 20'h00001);
        queue_eval(20'h00800, 20'h00800);
        queue_eval(20'h7F800, 20'h80400);
        queue_eval(20'hFFFFF, 20'h00800);
        queue_eval(20'hAAAAA, 20'h55555);
        queue_eval(20'h55555, 20'hAAAAA);
        // Load straight before reads of the same entries
        queue_load(8'h00, 8'hFF);
        queue_eval(20'h00000, 20'h00000);
        queue_load(8'hFF, 8'h00);
        queue_eval(20'hFF800, 20'h7F800);
        queue_load(8'h01, 8'h80);
        queue_load(8'h80, 8'h7F);
        queue_eval(20'h00C00, 20'h00400);
        queue_eval(20'h80FFF, 20'hFFFFE);

        // Random part: mostly evaluates, with loads that hit live reads
        n_rand = 0;
        while (n_rand < RAND_WORDS) begin
            case ($urandom_range(0, 9))
                0: begin
                    queue_load(t_byte'($urandom_range(0, 255)), t_byte'($urandom_range(0, 255)));
                    n_rand++;
                end
                1, 2: begin
                    idx = t_byte'($urandom_range(0, 255));
                    queue_load(idx, t_byte'($urandom_range(0, 255)));
                    n_rand++;
                    n_hit = $urandom_range(1, 3);
                    for (int k = 0; k < n_hit; k++) begin
                        cx = pick_coord();
                        cy = pick_coord();
                        if ($urandom_range(0, 1) == 0) begin
                            // Hit the entry on the first hash level
                            cx[COORD_W-1:FRAC_BITS] = idx - t_byte'($urandom_range(0, 1));
                        end else begin
                            // Hit the entry on the second hash level
                            cy[COORD_W-1:FRAC_BITS] = idx - perm_plan[cx[COORD_W-1:FRAC_BITS]]
                                                      - t_byte'($urandom_range(0, 1));
                        end
                        queue_eval(cx, cy);
                        n_rand++;
                    end
                end
                default: begin
                    queue_eval(pick_coord(), pick_coord());
                    n_rand++;
                end
            endcase
        end

        // Release reset
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait for every word to be taken and every result to arrive
        while (word_q.size() != 0 || tx_valid || noise_expected.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (err_cnt == 0 && noise_expected.size() == 0)
            $display("perlin_noise_2d_core: match");
        else
            $display("perlin_noise_2d_core: mismatch");
        $finish;
    end

    // ------------------------------------------------------------------
    // Driver: offer queued words, predict on acceptance
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : drv_proc
        pn_word_t w;
        bit       calm;
        if (!i_rst_n) begin
            tx_valid <= 1'b0;
            tx_gap   <= 0;
        end else begin
            calm = ((sent_cnt / 150) % 4) == 2;
            // Update the shadow table and predict on each accepted word
            if (tx_valid && o_ready) begin
                if (tx_op == OP_LOAD)
                    perm_shadow[tx_idx] = tx_val;
                else
                    noise_expected.push_back(noise_at(tx_x, tx_y));
                sent_cnt <= sent_cnt + 1;
            end
            // Advance to the next word once the current one is gone
            if (!tx_valid || o_ready) begin
                if (tx_gap != 0 || word_q.size() == 0) begin
                    tx_valid <= 1'b0;
                    if (tx_gap != 0)
                        tx_gap <= tx_gap - 1;
                end else begin
                    w = word_q.pop_front();
                    tx_valid <= 1'b1;
                    tx_op    <= w.op;
                    tx_idx   <= w.idx;
                    tx_val   <= w.val;
                    tx_x     <= w.x;
                    tx_y     <= w.y;
                    tx_gap   <= calm ? 0 : pick_gap();
                end
            end
        end
    end

    // Long receiver hold-off once the run is well under way
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (!hold_done && sent_cnt >= HOLD_AT) begin
            hold_left <= HOLD_LEN;
            hold_done <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: compare each result word with the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : mon_proc
        t_noise want;
        bit     calm;
        if (!i_rst_n) begin
            rx_ready <= 1'b0;
            rx_gap   <= 0;
        end else begin
            calm = ((rcv_cnt / 100) % 4) == 1;
            if (o_valid && rx_ready) begin
                rcv_cnt <= rcv_cnt + 1;
                if (noise_expected.size() == 0) begin
                    err_cnt++;
                    $display("%0t: unexpected result word, actual %0d",
                             $time, o_noise_value);
                end else begin
                    want = noise_expected.pop_front();
                    if (o_noise_value !== want) begin
                        err_cnt++;
                        $display("%0t: noise_value expected %0d actual %0d",
                                 $time, want, o_noise_value);
                    end
                end
            end
            // Stall at random, and drop ready for the whole hold-off
            if (hold_left != 0) begin
                rx_ready <= 1'b0;
            end else if (rx_gap != 0) begin
                rx_ready <= 1'b0;
                rx_gap   <= rx_gap - 1;
            end else if (!calm && $urandom_range(0, 99) < 20) begin
                rx_ready <= 1'b0;
                rx_gap   <= pick_gap();
            end else begin
                rx_ready <= 1'b1;
            end
        end
    end

    // Guard against a hang
    always @(posedge i_clk) begin
        cyc_cnt <= cyc_cnt + 1;
        if (cyc_cnt == CYCLE_LIMIT) begin
            $display("perlin_noise_2d_core: mismatch");
            $finish;
        end
    end

endmodule
